@@ src/ssd_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the sound / silence detector
// no dependencies

package ssd_pkg;

  localparam int THRESH_W = 13;
  localparam int LEVEL_W  = 16;
  localparam int TIME_W   = 32;
  localparam int PEAK_W   = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // detector states as seen on the result channel
  localparam logic [1:0] ST_SILENCE = 2'd0;
  localparam logic [1:0] ST_SOUND   = 2'd1;
  localparam logic [1:0] ST_LASTING = 2'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_THRESH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SND_STP = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SIL_STP = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FLOOR   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CEIL    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SND_ON  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SIL_ON  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_LASTING = 3'd7;

  typedef struct packed {
    logic        [THRESH_W-1:0] thresh;
    logic signed [LEVEL_W-1:0]  sound_step;
    logic signed [LEVEL_W-1:0]  silence_step;
    logic signed [LEVEL_W-1:0]  floor_lvl;
    logic signed [LEVEL_W-1:0]  ceil_lvl;
    logic signed [LEVEL_W-1:0]  sound_on;
    logic signed [LEVEL_W-1:0]  silence_on;
    logic        [TIME_W-1:0]   lasting_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic acc;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

@@ src/ssd_cfg.sv @@
`timescale 1ns / 1ps
// configuration register file of the sound / silence detector
// depends on ssd_pkg

module ssd_cfg
  import ssd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh       <= 13'd205;
      cfg_r.sound_step   <= 16'sd100;
      cfg_r.silence_step <= -16'sd100;
      cfg_r.floor_lvl    <= 16'sd0;
      cfg_r.ceil_lvl     <= 16'sd1000;
      cfg_r.sound_on     <= 16'sd800;
      cfg_r.silence_on   <= 16'sd200;
      cfg_r.lasting_ms   <= 32'd120000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESH:  cfg_r.thresh       <= cfg_wdata[THRESH_W-1:0];
        REG_SND_STP: cfg_r.sound_step   <= cfg_wdata[LEVEL_W-1:0];
        REG_SIL_STP: cfg_r.silence_step <= cfg_wdata[LEVEL_W-1:0];
        REG_FLOOR:   cfg_r.floor_lvl    <= cfg_wdata[LEVEL_W-1:0];
        REG_CEIL:    cfg_r.ceil_lvl     <= cfg_wdata[LEVEL_W-1:0];
        REG_SND_ON:  cfg_r.sound_on     <= cfg_wdata[LEVEL_W-1:0];
        REG_SIL_ON:  cfg_r.silence_on   <= cfg_wdata[LEVEL_W-1:0];
        REG_LASTING: cfg_r.lasting_ms   <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/ssd_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer of the sound / silence detector: load, multiply, divide, clamp, commit
// depends on ssd_pkg

module ssd_ctrl
  import ssd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // a result is never written over one that has not been taken
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

  // an accepted item always goes to the multiply step
  a_load_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL))
    else $error("accepted item did not start multiply");

  // the last divide step hands over to the clamp step
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_last) |=> (state_r == S_ACC))
    else $error("divide did not end in clamp step");

  // a commit always leaves a valid result
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without valid result");
`endif

endmodule

@@ src/ssd_datapath.sv @@
`timescale 1ns / 1ps
// datapath of the sound / silence detector: step product, serial divider,
// integrator clamp and hysteresis state; depends on ssd_pkg

module ssd_datapath
  import ssd_pkg::*;
#(
  parameter int FULL_SCALE = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic [PEAK_W-1:0]        in_peak_to_peak,
  input  logic [TIME_W-1:0]        in_now_ms,
  output logic [1:0]               out_sound_state,
  output logic                     out_state_changed,
  output logic signed [LEVEL_W-1:0] out_integrator_level
);

  localparam int PW     = $clog2(FULL_SCALE + 1);
  localparam int DW     = (PW > THRESH_W) ? PW : THRESH_W;
  localparam int MW     = LEVEL_W + DW;
  localparam int AW     = MW + 2;
  localparam int CNT_W  = $clog2(MW);
  localparam logic [PEAK_W:0] FS_V = (PEAK_W + 1)'(FULL_SCALE);

  // load stage
  logic [PEAK_W:0]          peak_ext;
  logic [PEAK_W:0]          peak_cl;
  logic [THRESH_W-1:0]      t_eff;
  logic [DW-1:0]            p_w, t_w;
  logic                     ge;
  logic [DW-1:0]            diff_r;
  logic signed [LEVEL_W-1:0] step_r;
  logic [THRESH_W-1:0]      t_r;
  logic [TIME_W-1:0]        now_r;

  // multiply and divide
  logic [LEVEL_W-1:0]       step_abs;
  logic                     neg_r;
  logic [MW-1:0]            quo_r;
  logic [THRESH_W-1:0]      rem_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [THRESH_W:0]        rem_sh;
  logic                     q_bit;

  // clamp
  logic signed [MW:0]       delta;
  logic signed [AW-1:0]     acc_v, acc_fl, acc_cl;
  logic signed [LEVEL_W-1:0] lvl_r;

  // detector state
  logic signed [LEVEL_W-1:0] integ_r;
  logic [1:0]               dstate_r;
  logic [TIME_W-1:0]        sstart_r;
  logic [1:0]               dstate_nxt;
  logic [TIME_W-1:0]        sstart_nxt;
  logic                     chg_nxt;
  logic [TIME_W-1:0]        elapsed;

  logic [1:0]               res_state_r;
  logic                     res_chg_r;
  logic signed [LEVEL_W-1:0] res_lvl_r;

  assign peak_ext = {1'b0, in_peak_to_peak};
  assign peak_cl  = (peak_ext > FS_V) ? FS_V : peak_ext;
  assign t_eff    = (cfg.thresh == '0) ? THRESH_W'(1) : cfg.thresh;
  assign p_w      = DW'(peak_cl[PW-1:0]);
  assign t_w      = DW'(t_eff);
  assign ge       = (p_w >= t_w);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_r <= ge ? (p_w - t_w) : (t_w - p_w);
      step_r <= ge ? cfg.sound_step : cfg.silence_step;
      t_r    <= t_eff;
      now_r  <= in_now_ms;
    end
  end

  // sign-magnitude product, so the quotient truncates toward zero
  assign step_abs = step_r[LEVEL_W-1] ? (~step_r + 1'b1) : step_r;

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[MW-1]};
  assign q_bit  = (rem_sh >= {1'b0, t_r});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r <= MW'(step_abs) * MW'(diff_r);
      neg_r <= step_r[LEVEL_W-1];
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? THRESH_W'(rem_sh - {1'b0, t_r}) : rem_sh[THRESH_W-1:0];
      quo_r <= {quo_r[MW-2:0], q_bit};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.div_last = (cnt_r == CNT_W'(MW - 1));

  // floor first, then ceiling, so the ceiling wins when they cross
  assign delta  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign acc_v  = AW'(integ_r) + AW'(delta);
  assign acc_fl = (acc_v < AW'(cfg.floor_lvl)) ? AW'(cfg.floor_lvl) : acc_v;
  assign acc_cl = (acc_fl > AW'(cfg.ceil_lvl)) ? AW'(cfg.ceil_lvl) : acc_fl;

  always_ff @(posedge clk) begin
    if (cmd.acc) lvl_r <= acc_cl[LEVEL_W-1:0];
  end

  assign elapsed = now_r - sstart_r;

  always_comb begin
    dstate_nxt = dstate_r;
    sstart_nxt = sstart_r;
    chg_nxt    = 1'b0;
    if ((dstate_r == ST_SILENCE || dstate_r == ST_LASTING) && lvl_r >= cfg.sound_on) begin
      dstate_nxt = ST_SOUND;
      chg_nxt    = 1'b1;
    end else if (dstate_r == ST_SOUND && lvl_r <= cfg.silence_on) begin
      dstate_nxt = ST_SILENCE;
      sstart_nxt = now_r;
      chg_nxt    = 1'b1;
    end else if (dstate_r == ST_SILENCE && elapsed >= cfg.lasting_ms) begin
      dstate_nxt = ST_LASTING;
      chg_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= '0;
      dstate_r <= ST_SILENCE;
      sstart_r <= '0;
    end else if (cmd.commit) begin
      integ_r  <= lvl_r;
      dstate_r <= dstate_nxt;
      sstart_r <= sstart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_state_r <= dstate_nxt;
      res_chg_r   <= chg_nxt;
      res_lvl_r   <= lvl_r;
    end
  end

  assign out_sound_state      = res_state_r;
  assign out_state_changed    = res_chg_r;
  assign out_integrator_level = res_lvl_r;

endmodule

@@ src/sound_silence_detector.sv @@
`timescale 1ns / 1ps
// sound / silence detector top level: one result per accepted frame
// sequence: after the input transfer a frame passes the multiply, serial divide, clamp
//   and commit steps; the commit waits while an untaken result is still held
// one frame in flight: the next frame is taken once its result is staged
// reset: rst_n synchronous active low, clears sequencer, integrator and state, loads register defaults

module sound_silence_detector
  import ssd_pkg::*;
#(
  parameter int FULL_SCALE = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PEAK_W-1:0]         in_peak_to_peak,
  input  logic [TIME_W-1:0]         in_now_ms,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_sound_state,
  output logic                      out_state_changed,
  output logic signed [LEVEL_W-1:0] out_integrator_level,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [CFG_AW-1:0]         cfg_index,
  input  logic [CFG_DW-1:0]         cfg_wdata
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // register file; the user must write it only while no frame is in flight, the block does not enforce this
  ssd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: idle, multiply, divide steps, clamp, commit into result register
  ssd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, integrator and hysteresis state, result register
  ssd_datapath #(
    .FULL_SCALE (FULL_SCALE)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .status               (status),
    .in_peak_to_peak      (in_peak_to_peak),
    .in_now_ms            (in_now_ms),
    .out_sound_state      (out_sound_state),
    .out_state_changed    (out_state_changed),
    .out_integrator_level (out_integrator_level)
  );

endmodule

@@ dv/sound_silence_detector_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the sound / silence detector: a driver fed from a frame queue,
// a stalling result monitor and a frame-level predictor of the integrator and state machine
// depends on ssd_pkg and the sound_silence_detector top level

module sound_silence_detector_tb;
  import ssd_pkg::*;

  localparam int FULL_SCALE       = 4096;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int FRAMES_PER_PHASE = 82;
  // timestamps of the directed quiet run sit just below the 32-bit wrap
  localparam logic [TIME_W-1:0] WRAP_BASE = 32'hFFFF_FF00;

  typedef enum int {
    SET_DEFAULT,
    SET_EXTREME_LO,
    SET_EXTREME_HI,
    SET_ZERO_THRESH,
    SET_RANDOM
  } setting_e;

  typedef enum int {RUN_LOUD, RUN_QUIET, RUN_NOISE} run_kind_e;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct {
    logic [PEAK_W-1:0] peak;
    logic [TIME_W-1:0] now;
    bit                drain_first;  // hold this frame back until every result is in
  } frame_t;

  typedef struct {
    logic [1:0]                state;
    logic                      changed;
    logic signed [LEVEL_W-1:0] level;
  } verdict_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [PEAK_W-1:0]         in_peak_to_peak = '0;
  logic [TIME_W-1:0]         in_now_ms = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                out_sound_state;
  logic                      out_state_changed;
  logic signed [LEVEL_W-1:0] out_integrator_level;
  logic                      cfg_we = 1'b0;
  logic [CFG_AW-1:0]         cfg_index = '0;
  logic [CFG_DW-1:0]         cfg_wdata = '0;

  always #2 clk = ~clk;

  sound_silence_detector #(
    .FULL_SCALE(FULL_SCALE)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_peak_to_peak     (in_peak_to_peak),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sound_state     (out_sound_state),
    .out_state_changed   (out_state_changed),
    .out_integrator_level(out_integrator_level),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // predictor copy of the registers and of the detector state
  cfg_t                      regs;
  logic signed [LEVEL_W-1:0] integ;
  logic [1:0]                det_state;
  logic [TIME_W-1:0]         quiet_since;

  frame_t   frames_to_send[$];
  verdict_t due_verdicts[$];
  verdict_t want;

  int          issued;
  int          accepted;
  int          burst_left;
  int          gap_left;
  int          fail_count;
  int          cycle_count;
  int          rx_left;
  int          rx_tick;
  rx_mode_e    rx_mode = RX_OPEN;
  logic [TIME_W-1:0] clock_ms;

  // one frame through the leaky integrator and the three-state machine
  function automatic verdict_t advance_detector(input logic [PEAK_W-1:0] peak,
                                                input logic [TIME_W-1:0] now);
    verdict_t          v;
    longint            p;
    longint            t;
    longint            delta;
    longint            acc;
    logic [TIME_W-1:0] quiet_ms;
    p = longint'(peak);
    if (p > FULL_SCALE) p = FULL_SCALE;
    t = longint'(regs.thresh);
    // a zero threshold counts as one
    if (t == 0) t = 1;
    if (p >= t) delta = (longint'($signed(regs.sound_step)) * (p - t)) / t;
    else delta = (longint'($signed(regs.silence_step)) * (t - p)) / t;
    acc = longint'(integ) + delta;
    // floor first, ceiling last: an inverted pair ends on the ceiling
    if (acc < longint'($signed(regs.floor_lvl))) acc = longint'($signed(regs.floor_lvl));
    if (acc > longint'($signed(regs.ceil_lvl))) acc = longint'($signed(regs.ceil_lvl));
    integ = acc[LEVEL_W-1:0];
    quiet_ms = now - quiet_since;
    v.changed = 1'b0;
    // sound-on wins, then silence-on, then the timeout; one move per frame
    if ((det_state == ST_SILENCE || det_state == ST_LASTING) &&
        integ >= $signed(regs.sound_on)) begin
      det_state = ST_SOUND;
      v.changed = 1'b1;
    end else if (det_state == ST_SOUND && integ <= $signed(regs.silence_on)) begin
      det_state   = ST_SILENCE;
      quiet_since = now;
      v.changed   = 1'b1;
    end else if (det_state == ST_SILENCE && quiet_ms >= regs.lasting_ms) begin
      det_state = ST_LASTING;
      v.changed = 1'b1;
    end
    v.state = det_state;
    v.level = integ;
    return v;
  endfunction

  // driver: bursts of frames with random gaps, expectation taken at each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_verdicts.push_back(advance_detector(in_peak_to_peak, in_now_ms));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (frames_to_send.size() > 0 &&
                     !(frames_to_send[0].drain_first && due_verdicts.size() > 0)) begin
          in_peak_to_peak <= frames_to_send[0].peak;
          in_now_ms       <= frames_to_send[0].now;
          in_valid        <= 1'b1;
          void'(frames_to_send.pop_front());
          issued++;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a zero gap now and then gives long runs with no idle cycle
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and stalls on a changing pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_verdicts.size() == 0) begin
          $error("result transfer with nothing expected: state %0d level %0d",
                 out_sound_state, out_integrator_level);
          fail_count++;
        end else begin
          want = due_verdicts.pop_front();
          if (out_sound_state !== want.state) begin
            $error("sound_state: expected %0d, actual %0d", want.state, out_sound_state);
            fail_count++;
          end
          if (out_state_changed !== want.changed) begin
            $error("state_changed: expected %0d, actual %0d", want.changed, out_state_changed);
            fail_count++;
          end
          if (out_integrator_level !== want.level) begin
            $error("integrator_level: expected %0d, actual %0d", want.level,
                   out_integrator_level);
            fail_count++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
        default:   out_ready <= (rx_tick % 9) < 3;
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sound_silence_detector_tb NOT OK");
      $finish;
    end
  end

  task automatic push_frame(input logic [PEAK_W-1:0] peak, input logic [TIME_W-1:0] now,
                            input bit drain);
    frame_t f;
    f.peak        = peak;
    f.now         = now;
    f.drain_first = drain;
    frames_to_send.push_back(f);
  endtask

  // every frame sent, transferred and answered
  task automatic wait_drained();
    while (frames_to_send.size() != 0 || issued != accepted || due_verdicts.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESH:  regs.thresh       = d[THRESH_W-1:0];
      REG_SND_STP: regs.sound_step   = d[LEVEL_W-1:0];
      REG_SIL_STP: regs.silence_step = d[LEVEL_W-1:0];
      REG_FLOOR:   regs.floor_lvl    = d[LEVEL_W-1:0];
      REG_CEIL:    regs.ceil_lvl     = d[LEVEL_W-1:0];
      REG_SND_ON:  regs.sound_on     = d[LEVEL_W-1:0];
      REG_SIL_ON:  regs.silence_on   = d[LEVEL_W-1:0];
      REG_LASTING: regs.lasting_ms   = d;
      default: ;
    endcase
  endtask

  // writes all eight registers for one phase
  task automatic program_settings(input setting_e kind);
    int                th;
    int                snd;
    int                sil;
    int                flo;
    int                cei;
    int                son;
    int                sof;
    logic [TIME_W-1:0] lst;
    case (kind)
      SET_DEFAULT: begin
        th = 205; snd = 100; sil = -100; flo = 0; cei = 1000; son = 800; sof = 200;
        lst = 120000;
      end
      SET_EXTREME_LO: begin
        th = 1; snd = 32767; sil = -32768; flo = -32768; cei = 32767; son = 0; sof = -1;
        lst = 0;
      end
      SET_EXTREME_HI: begin
        // threshold beyond full scale, inverted clamp pair, longest timeout
        th = 8191; snd = -32768; sil = 32767; flo = 32767; cei = -32768; son = -32768;
        sof = 32767; lst = 32'hFFFF_FFFF;
      end
      SET_ZERO_THRESH: begin
        th = 0; snd = $urandom_range(1, 50); sil = 0 - int'($urandom_range(1, 50));
        flo = -300; cei = 300; son = 150; sof = -150; lst = $urandom_range(0, 500);
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       th = 0;
          1:       th = $urandom_range(FULL_SCALE + 1, 8191);
          2, 3:    th = $urandom_range(1, 16);
          default: th = $urandom_range(1, FULL_SCALE);
        endcase
        if ($urandom_range(0, 6) == 0) snd = int'($urandom_range(0, 65535)) - 32768;
        else snd = $urandom_range(1, 2000);
        if ($urandom_range(0, 6) == 0) sil = int'($urandom_range(0, 65535)) - 32768;
        else sil = 0 - int'($urandom_range(1, 2000));
        if ($urandom_range(0, 9) == 0) begin
          flo = int'($urandom_range(0, 65535)) - 32768;
          cei = int'($urandom_range(0, 65535)) - 32768;
          son = int'($urandom_range(0, 65535)) - 32768;
          sof = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          // hysteresis levels inside the clamp range so the state machine moves
          flo = 0 - int'($urandom_range(0, 2000));
          cei = flo + int'($urandom_range(200, 4000));
          son = cei - int'($urandom_range(0, (cei - flo) / 3));
          sof = flo + int'($urandom_range(0, (cei - flo) / 3));
        end
        case ($urandom_range(0, 4))
          0, 1:    lst = $urandom_range(0, 3000);
          2:       lst = $urandom;
          default: lst = $urandom_range(3000, 200000);
        endcase
      end
    endcase
    write_reg(REG_THRESH, th);
    write_reg(REG_SND_STP, snd);
    write_reg(REG_SIL_STP, sil);
    write_reg(REG_FLOOR, flo);
    write_reg(REG_CEIL, cei);
    write_reg(REG_SND_ON, son);
    write_reg(REG_SIL_ON, sof);
    write_reg(REG_LASTING, lst);
  endtask

  // runs of loud and quiet frames on an advancing clock, with some noise
  task automatic gen_frames(input int n);
    int                run_left;
    int                peak;
    int                t_eff;
    run_kind_e         run;
    logic [TIME_W-1:0] stamp;
    run_left = 0;
    run      = RUN_QUIET;
    t_eff    = (regs.thresh == 0) ? 1 : int'(regs.thresh);
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 14);
        case ($urandom_range(0, 9))
          0:             run = RUN_NOISE;
          1, 2, 3, 4, 5: run = RUN_LOUD;
          default:       run = RUN_QUIET;
        endcase
      end
      run_left--;
      case (run)
        RUN_LOUD: begin
          if (t_eff > FULL_SCALE || $urandom_range(0, 4) == 0)
            peak = $urandom_range(FULL_SCALE, 65535);
          else peak = $urandom_range(t_eff, FULL_SCALE);
        end
        RUN_QUIET: peak = (t_eff == 1) ? 0 : $urandom_range(0, t_eff - 1);
        default:   peak = $urandom_range(0, 65535);
      endcase
      // right at the threshold or one below
      if ($urandom_range(0, 19) == 0) peak = t_eff - int'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: stamp = $urandom;  // stray timestamp, clock left alone
        1: begin
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
          stamp    = clock_ms;
        end
        2, 3, 4, 5: begin
          clock_ms += (regs.lasting_ms >> $urandom_range(1, 3)) + $urandom_range(0, 3);
          stamp = clock_ms;
        end
        default: begin
          clock_ms += $urandom_range(0, 40);
          stamp = clock_ms;
        end
      endcase
      push_frame(PEAK_W'(peak), stamp, i == 10 || $urandom_range(0, 99) == 0);
    end
  endtask

  initial begin
    regs.thresh       = 205;
    regs.sound_step   = 100;
    regs.silence_step = -100;
    regs.floor_lvl    = 0;
    regs.ceil_lvl     = 1000;
    regs.sound_on     = 800;
    regs.silence_on   = 200;
    regs.lasting_ms   = 120000;
    integ       = '0;
    det_state   = ST_SILENCE;
    quiet_since = '0;
    clock_ms    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: threshold edges, full-scale clamp, into sound
    push_frame(16'd0, 32'd0, 1'b0);
    push_frame(16'd205, 32'd10, 1'b0);
    push_frame(16'd204, 32'd20, 1'b0);
    push_frame(16'd206, 32'd30, 1'b0);
    push_frame(16'hFFFF, 32'd40, 1'b0);
    push_frame(16'd4096, 32'd50, 1'b0);
    push_frame(16'd4097, 32'd60, 1'b0);
    // quiet run down to silence-on, stamped just before the time wrap
    for (int i = 0; i < 8; i++) push_frame(16'd0, WRAP_BASE + i, 1'b0);
    // timeout across the wrap: one short, then exactly there, then back to sound
    push_frame(16'd0, WRAP_BASE + 7 + 119999, 1'b0);
    push_frame(16'd0, WRAP_BASE + 7 + 120000, 1'b0);
    push_frame(16'hFFFF, WRAP_BASE + 7 + 120001, 1'b0);
    wait_drained();

    // zero threshold with the floor above the ceiling
    write_reg(REG_THRESH, 0);
    write_reg(REG_FLOOR, 500);
    write_reg(REG_CEIL, 100);
    push_frame(16'd0, 32'd5, 1'b0);
    push_frame(16'd1, 32'd6, 1'b0);
    push_frame(16'd3000, 32'd7, 1'b0);
    wait_drained();

    // threshold beyond full scale: only silence steps
    write_reg(REG_THRESH, 8191);
    push_frame(16'hFFFF, 32'd8, 1'b0);
    push_frame(16'd4096, 32'd9, 1'b0);
    wait_drained();

    // random phases, each with its own register settings
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) program_settings(setting_e'(ph + 1));
      else if (ph == 8) program_settings(SET_DEFAULT);
      else program_settings(SET_RANDOM);
      gen_frames(FRAMES_PER_PHASE);
      wait_drained();
    end

    // let any stray result show up
    repeat (40) @(posedge clk);
    if (due_verdicts.size() != 0) begin
      $error("%0d results never arrived", due_verdicts.size());
      fail_count++;
    end
    if (fail_count == 0) $display("sound_silence_detector_tb OK");
    else $display("sound_silence_detector_tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
src/ssd_pkg.sv
src/ssd_cfg.sv
src/ssd_ctrl.sv
src/ssd_datapath.sv
src/sound_silence_detector.sv
dv/sound_silence_detector_tb.sv
